// File: src/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// shared types, codes and defaults of the lru key/value cache
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int KEY_W           = 32;
  localparam int VAL_W           = 32;
  localparam int CAP_W           = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_ENCODE,
    ST_PROMOTE,
    ST_EVICT,
    ST_INSERT,
    ST_RESULT
  } lkv_state_t;

  typedef struct packed {
    logic load;
    logic match;
    logic encode;
    logic promote;
    logic rd_en;
    logic wr_en;
    logic evict;
    logic insert;
    logic out_load;
  } lkv_cmd_t;

  typedef struct packed {
    logic is_set;
    logic hit;
    logic out_free;
  } lkv_status_t;

endpackage

// File: src/lkv_if.sv
// ----------------------------------------------------------------------------
// lkv_if
// request and result channels of the lru key/value cache
// ----------------------------------------------------------------------------
interface lkv_req_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] lookup_key;
  logic signed [31:0] write_value;

  modport source (output valid, output command, output lookup_key, output write_value,
                  input ready);
  modport sink (input valid, input command, input lookup_key, input write_value,
                output ready);
endinterface

interface lkv_rsp_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic signed [31:0] read_value;

  modport source (output valid, output found, output read_value, input ready);
  modport sink (input valid, input found, input read_value, output ready);
endinterface

// File: src/lkv_ram.sv
// ----------------------------------------------------------------------------
// lkv_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl
// request sequencer: match, encode, then promote or evict and insert
// ----------------------------------------------------------------------------
module lkv_ctrl
  import lkv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  lkv_status_t status,
  output lkv_cmd_t    cmd
);

  lkv_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MATCH;
      end
      ST_MATCH:  state_nxt = ST_ENCODE;
      ST_ENCODE: begin
        if (status.hit) begin
          state_nxt = ST_PROMOTE;
        end else if (status.is_set) begin
          state_nxt = ST_EVICT;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_PROMOTE: state_nxt = ST_RESULT;
      ST_EVICT:   state_nxt = ST_INSERT;
      ST_INSERT:  state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MATCH:  cmd.match = 1'b1;
      ST_ENCODE: cmd.encode = 1'b1;
      ST_PROMOTE: begin
        cmd.promote = 1'b1;
        cmd.rd_en   = !status.is_set;
        cmd.wr_en   = status.is_set;
      end
      ST_EVICT: cmd.evict = 1'b1;
      ST_INSERT: begin
        cmd.insert = 1'b1;
        cmd.wr_en  = 1'b1;
      end
      ST_RESULT: cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: src/lkv_datapath.sv
// ----------------------------------------------------------------------------
// lkv_datapath
// entry keys, valid bits, age ranks, value ram and result register
// ----------------------------------------------------------------------------
module lkv_datapath
  import lkv_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CAP_W-1:0]   cfg_wr_data,
  input  logic               in_command,
  input  logic [KEY_W-1:0]   in_lookup_key,
  input  logic [VAL_W-1:0]   in_write_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic [VAL_W-1:0]   out_read_value,
  input  lkv_cmd_t           cmd,
  output lkv_status_t        status
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [8:0] MAX_W9 = 9'(MAX_ENTRIES);

  logic [CAP_W-1:0]       cap_r;
  logic                   cmd_r;
  logic [KEY_W-1:0]       key_r;
  logic [VAL_W-1:0]       value_r;
  logic [KEY_W-1:0]       keys_r [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_r;
  logic [IDX_W-1:0]       rank_r [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] hit_vec_r;
  logic                   hit_any_r;
  logic [IDX_W-1:0]       hit_idx_r;
  logic [IDX_W-1:0]       hit_rank_r;
  logic                   out_valid_r;
  logic                   out_found_r;
  logic [VAL_W-1:0]       out_value_r;

  logic [IDX_W-1:0]       hit_idx_nxt;
  logic [IDX_W-1:0]       hit_rank_nxt;
  logic [MAX_ENTRIES-1:0] free_oh;
  logic [IDX_W-1:0]       free_idx;
  logic [8:0]             limit;
  logic                   ram_wr_en;
  logic [IDX_W-1:0]       ram_wr_addr;
  logic [VAL_W-1:0]       ram_rd_data;

  always_comb begin
    if (cap_r == '0) begin
      limit = 9'd0;
    end else if (9'(cap_r) > MAX_W9) begin
      limit = MAX_W9 - 9'd1;
    end else begin
      limit = 9'(cap_r) - 9'd1;
    end
  end

  always_comb begin
    hit_idx_nxt  = '0;
    hit_rank_nxt = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (hit_vec_r[i]) begin
        hit_idx_nxt  = hit_idx_nxt | IDX_W'(i);
        hit_rank_nxt = hit_rank_nxt | rank_r[i];
      end
    end
  end

  always_comb begin
    free_oh  = '0;
    free_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_oh  = '0;
        free_oh[i] = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_command;
      key_r   <= in_lookup_key;
      value_r <= in_write_value;
    end
    if (cmd.match) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        hit_vec_r[i] <= valid_r[i] && (keys_r[i] == key_r);
      end
    end
    if (cmd.encode) begin
      hit_any_r  <= |hit_vec_r;
      hit_idx_r  <= hit_idx_nxt;
      hit_rank_r <= hit_rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (cmd.promote) begin
          if (hit_vec_r[i]) begin
            rank_r[i] <= '0;
          end else if (valid_r[i] && (rank_r[i] < hit_rank_r)) begin
            rank_r[i] <= rank_r[i] + IDX_W'(1);
          end
        end
        if (cmd.evict && valid_r[i] && (9'(rank_r[i]) >= limit)) begin
          valid_r[i] <= 1'b0;
        end
        if (cmd.insert) begin
          if (free_oh[i]) begin
            valid_r[i] <= 1'b1;
            rank_r[i]  <= '0;
          end else if (valid_r[i]) begin
            rank_r[i] <= rank_r[i] + IDX_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (cmd.insert && free_oh[i]) begin
        keys_r[i] <= key_r;
      end
    end
  end

  assign ram_wr_en   = cmd.wr_en;
  assign ram_wr_addr = cmd.insert ? free_idx : hit_idx_r;

  lkv_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ENTRIES)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (value_r),
    .rd_en   (cmd.rd_en),
    .rd_addr (hit_idx_r),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found_r <= hit_any_r;
      out_value_r <= (hit_any_r && (cmd_r == CMD_GET)) ? ram_rd_data : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_read_value  = out_value_r;

  assign status.is_set   = (cmd_r == CMD_SET);
  assign status.hit      = |hit_vec_r;
  assign status.out_free = !out_valid_r || out_ready;

endmodule

// File: src/lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// fully associative key/value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// One request is in flight at a time. A get miss passes through accept, match,
// encode and result, a hit (get or set) adds promote, and a set of a new key
// adds evict and insert; the result register is loaded at the end
// of the last of these steps and the next request is accepted in
// the cycle after. The result register lets a new request in while the
// previous result still waits; a result that is still waiting when the next
// one is ready holds the sequencer in its result step. The sequence is set by
// the single key compare stage and the one write port of the value ram.
// Capacity is written through cfg_wr_en/cfg_wr_data, clamped to
// 1..MAX_ENTRIES, and takes effect on the next set of a new key.
module lru_key_value_cache_unit
  import lkv_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  lkv_req_if.sink          in_chan,
  lkv_rsp_if.source        out_chan,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data
);

  lkv_cmd_t    cmd;
  lkv_status_t status;
  logic [VAL_W-1:0] read_value;

  lkv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lkv_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_command     (in_chan.command),
    .in_lookup_key  (in_chan.lookup_key),
    .in_write_value (in_chan.write_value),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_found      (out_chan.found),
    .out_read_value (read_value),
    .cmd            (cmd),
    .status         (status)
  );

  assign out_chan.read_value = read_value;

endmodule

// File: bench/tb_lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_unit
// self-checking bench for the lru key/value cache: a cycle-free shadow of the
// cache predicts found/read_value for every accepted request, and each result
// is compared in order; directed cases, capacity changes, back-pressure and
// random get/set traffic under varying idle patterns on both channels
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_unit;
  import lkv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE   = 24;

  typedef struct {
    logic               found;
    logic signed [31:0] read_value;
  } reply_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;

  lkv_req_if req_bus ();
  lkv_rsp_if rsp_bus ();

  lru_key_value_cache_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (req_bus),
    .out_chan    (rsp_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // shadow of the cache contents
  logic [31:0]      slot_key   [MAX_ENTRIES_DEF];
  logic [31:0]      slot_value [MAX_ENTRIES_DEF];
  logic             slot_live  [MAX_ENTRIES_DEF];
  logic [3:0]       slot_age   [MAX_ENTRIES_DEF];
  logic [CAP_W-1:0] cap_setting;

  reply_t      cache_replies[$];
  logic [31:0] key_pool[POOL_SIZE];
  int          error_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_ask;
  int          hold_left;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_error(string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic reply_t lru_access(logic cmd, logic [31:0] key, logic [31:0] val);
    reply_t     r;
    int         hit;
    int         eff;
    int         free_slot;
    logic [3:0] rank;
    r.found = 1'b0;
    r.read_value = '0;
    hit = -1;
    for (int i = 0; i < MAX_ENTRIES_DEF; i++)
      if (hit < 0 && slot_live[i] && slot_key[i] == key) hit = i;
    if (hit >= 0) begin
      r.found = 1'b1;
      if (cmd == CMD_GET) r.read_value = slot_value[hit];
      else slot_value[hit] = val;
      rank = slot_age[hit];
      for (int i = 0; i < MAX_ENTRIES_DEF; i++)
        if (slot_live[i] && slot_age[i] < rank) slot_age[i] = slot_age[i] + 1'b1;
      slot_age[hit] = '0;
    end else if (cmd == CMD_SET) begin
      eff = (cap_setting == 0) ? 1 :
            (cap_setting > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(cap_setting);
      // drop everything at or past the new tail before inserting
      for (int i = 0; i < MAX_ENTRIES_DEF; i++)
        if (slot_live[i] && int'(slot_age[i]) >= eff - 1) slot_live[i] = 1'b0;
      free_slot = -1;
      for (int i = 0; i < MAX_ENTRIES_DEF; i++) begin
        if (slot_live[i]) slot_age[i] = slot_age[i] + 1'b1;
        else if (free_slot < 0) free_slot = i;
      end
      if (free_slot >= 0) begin
        slot_key[free_slot] = key;
        slot_value[free_slot] = val;
        slot_live[free_slot] = 1'b1;
        slot_age[free_slot] = '0;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_ENTRIES_DEF; i++) begin
        slot_live[i] = 1'b0;
        slot_age[i] = '0;
        slot_key[i] = '0;
        slot_value[i] = '0;
      end
      cap_setting = CAP_RESET;
    end else begin
      if (cfg_wr_en) cap_setting = cfg_wr_data;
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (cache_replies.size() == 0) begin
          report_error("result with no request outstanding");
        end else begin
          want = cache_replies.pop_front();
          if (rsp_bus.found !== want.found)
            report_error($sformatf("found: expected %0b got %0b", want.found, rsp_bus.found));
          if (rsp_bus.read_value !== want.read_value)
            report_error($sformatf("read_value: expected %08h got %08h",
                                   want.read_value, rsp_bus.read_value));
        end
      end
      if (req_bus.valid && req_bus.ready)
        cache_replies.push_back(lru_access(req_bus.command, req_bus.lookup_key,
                                           req_bus.write_value));
    end
  end

  // result side: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_left == 0 && hold_ask != 0) begin
      hold_left = hold_ask;
      hold_ask = 0;
    end
    if (hold_left != 0) begin
      rsp_bus.ready = 1'b0;
      hold_left--;
    end else begin
      rsp_bus.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_request(logic cmd, logic [31:0] key, logic [31:0] val);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid = 1'b0;
      @(negedge clk);
    end
    req_bus.valid = 1'b1;
    req_bus.command = cmd;
    req_bus.lookup_key = key;
    req_bus.write_value = val;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_bus.valid = 1'b0;
    while (cache_replies.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    wait_idle();
    cfg_wr_en = 1'b1;
    cfg_wr_data = cap;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic refill_key_pool();
    for (int k = 0; k < POOL_SIZE; k++) key_pool[k] = $urandom;
    if ($urandom_range(3) == 0) begin
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hffff_ffff;
    end
  endtask

  task automatic send_random(int span);
    logic [31:0] key;
    if ($urandom_range(9) == 0) key = $urandom;
    else key = key_pool[$urandom_range(span)];
    send_request(1'($urandom_range(1)), key, $urandom);
  endtask

  task automatic test_empty_lookup();
    send_request(CMD_GET, 32'h0000_0000, 32'hffff_ffff);
    send_request(CMD_GET, 32'h8000_0000, 32'h0000_0000);
  endtask

  task automatic test_set_and_get();
    send_request(CMD_SET, 32'h8000_0000, 32'h7fff_ffff);
    send_request(CMD_SET, 32'h7fff_ffff, 32'h8000_0000);
    send_request(CMD_SET, 32'h0000_0000, 32'hffff_ffff);
    send_request(CMD_SET, 32'hffff_ffff, 32'h0000_0000);
    send_request(CMD_SET, 32'h8000_0000, 32'h5a5a_a5a5);
    send_request(CMD_GET, 32'h8000_0000, 32'h1234_5678);
    send_request(CMD_GET, 32'hffff_ffff, 32'hffff_ffff);
    send_request(CMD_GET, 32'h0001_2345, 32'h0000_0000);
  endtask

  task automatic test_capacity_lowered();
    write_capacity(5'd2);
    send_request(CMD_GET, 32'h7fff_ffff, 32'h0000_0000);
    send_request(CMD_SET, 32'h0000_1234, 32'hdead_beef);
    send_request(CMD_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(CMD_GET, 32'h7fff_ffff, 32'h0000_0000);
    send_request(CMD_SET, 32'h0000_5678, 32'hcafe_f00d);
    send_request(CMD_GET, 32'h0000_1234, 32'h0000_0000);
  endtask

  task automatic test_capacity_limits();
    write_capacity(5'd0);
    send_request(CMD_SET, 32'h0bad_cafe, 32'h1357_9bdf);
    send_request(CMD_GET, 32'h0bad_cafe, 32'h0000_0000);
    send_request(CMD_GET, 32'h0000_5678, 32'h0000_0000);
    write_capacity(5'd31);
    send_request(CMD_SET, 32'h2468_ace0, 32'hffff_0000);
    send_request(CMD_GET, 32'h0bad_cafe, 32'h0000_0000);
    write_capacity(5'd17);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capacity(5'd16);
    refill_key_pool();
    hold_ask = 300;
    repeat (30) send_random(19);
  endtask

  task automatic test_random_traffic(int n_items, int s_idle, int r_idle);
    int cap;
    int span;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int sent = 0; sent < n_items; sent += 60) begin
      cap = $urandom_range(31);
      write_capacity(cap[CAP_W-1:0]);
      refill_key_pool();
      span = (cap == 0) ? 4 : (cap > 16) ? 19 : cap + 3;
      repeat (60) send_random(span);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_bus.valid = 1'b0;
    req_bus.command = CMD_GET;
    req_bus.lookup_key = '0;
    req_bus.write_value = '0;
    rsp_bus.ready = 1'b0;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_ask = 0;
    hold_left = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_empty_lookup();
    test_set_and_get();
    test_capacity_lowered();
    test_capacity_limits();
    test_backpressure();
    test_random_traffic(360, 11, 73);
    test_random_traffic(360, 73, 11);
    test_random_traffic(360, 0, 0);
    wait_idle();

    if (cache_replies.size() != 0) report_error("requests left without a result");
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/lkv_pkg.sv
src/lkv_if.sv
src/lkv_ram.sv
src/lkv_ctrl.sv
src/lkv_datapath.sv
src/lru_key_value_cache_unit.sv
bench/tb_lru_key_value_cache_unit.sv
